FILE: src/wip_pkg.sv
// ----------------------------------------------------------------------------
// wip_pkg
// Shared widths, command and register codes, result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package wip_pkg;

   localparam int XY_W         = 32;  // signed Q16.16 coordinate
   localparam int FRAC_W       = 16;  // fraction bits of Q16.16
   localparam int STEP_COUNT_W = 7;
   localparam int TARGET_W     = 4;
   localparam int SLOT_W       = 6;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic CSR_STEP_COUNT = 1'b0;
   localparam logic CSR_TIME_STEP  = 1'b1;

   typedef struct packed {
      logic [XY_W-1:0] now_x;
      logic [XY_W-1:0] now_y;
      logic [XY_W-1:0] ahead_x;
      logic [XY_W-1:0] ahead_y;
      logic            no_waypoints;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/wip_ram.sv
// ----------------------------------------------------------------------------
// wip_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wip_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr_a,
   input  logic [ADDR_W-1:0] raddr_b,
   output logic [WIDTH-1:0]  rdata_a,
   output logic [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end

endmodule

`default_nettype wire

FILE: src/wip_div_pipe.sv
// ----------------------------------------------------------------------------
// wip_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module wip_div_pipe #(
   parameter int NUM_W  = 47,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [SIDE_W-1:0] in_side,
   input  logic [DEN_W-1:0]  den,       // held steady while beats are in flight
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [DEN_W-1:0]  out_rem,
   output logic [SIDE_W-1:0] out_side
);

   // acc holds the unconsumed dividend bits on top, quotient bits below
   logic [NUM_W-1:0]  acc_ff  [NUM_W];
   logic [NUM_W-1:0]  acc_in  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_in  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic [SIDE_W-1:0] side_in [NUM_W];
   logic [NUM_W-1:0]  valid_ff;
   logic [NUM_W-1:0]  valid_in;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [NUM_W-1:0]  acc_src;
      logic [DEN_W-1:0]  rem_src;
      logic [SIDE_W-1:0] side_src;
      logic              vld_src;
      logic [DEN_W:0]    trial;
      logic              fits;

      if (k == 0) begin : g_first
         assign acc_src  = in_num;
         assign rem_src  = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign acc_src  = acc_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = valid_ff[k-1];
      end

      assign trial       = {rem_src, acc_src[NUM_W-1]};
      assign fits        = (trial >= {1'b0, den});
      assign acc_in[k]   = {acc_src[NUM_W-2:0], fits};
      assign rem_in[k]   = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      assign side_in[k]  = side_src;
      assign valid_in[k] = vld_src;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_W; i++) begin
            acc_ff[i]  <= acc_in[i];
            rem_ff[i]  <= rem_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = acc_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

`default_nettype wire

FILE: src/waypoint_interp_predict_core.sv
// ----------------------------------------------------------------------------
// waypoint_interp_predict_core
// Per-target waypoint store with cyclic linear interpolation and prediction.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | beat contents
// req_    | in  | valid / ready    | cmd, target, slot, write x/y, time, lookahead
// rsp_    | out | valid / ready    | now x/y, ahead x/y, no_waypoints
// csr_    | in  | valid / ready=1  | index (0 step_count, 1 time_step), data
//
// One beat per cycle in and out while the pipe advances. Accept to rsp_valid
// spans 47 time-divider stages, 31 index-modulo stages, 1 RAM read, 4
// arithmetic stages, 64 lookahead-divider stages, 1 sign fix and 1 output
// queue write. The whole pipe moves on one advance strobe; it stops only when
// the two-entry output queue is full and rsp_ready is low, so a waiting result
// does not block new requests. Waypoint stores have no reset; csr writes apply
// at once; the user must make them only with the pipe empty (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_interp_predict_core #(
   parameter int MAX_TARGETS = 16,
   parameter int MAX_STEPS   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // request beats
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [wip_pkg::TARGET_W-1:0]    req_target,
   input  logic [wip_pkg::SLOT_W-1:0]      req_waypoint_slot,
   input  logic signed [wip_pkg::XY_W-1:0] req_write_x,
   input  logic signed [wip_pkg::XY_W-1:0] req_write_y,
   input  logic signed [wip_pkg::XY_W-1:0] req_query_time,
   input  logic signed [wip_pkg::XY_W-1:0] req_lookahead,
   // response beats
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [wip_pkg::XY_W-1:0] rsp_now_x,
   output logic signed [wip_pkg::XY_W-1:0] rsp_now_y,
   output logic signed [wip_pkg::XY_W-1:0] rsp_ahead_x,
   output logic signed [wip_pkg::XY_W-1:0] rsp_ahead_y,
   output logic                            rsp_no_waypoints,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [wip_pkg::XY_W-1:0]        csr_data
);

   import wip_pkg::*;

   localparam int TW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int SW    = $clog2(MAX_STEPS);
   localparam int NW    = $clog2(MAX_STEPS + 1);
   localparam int DEPTH = MAX_TARGETS * MAX_STEPS;
   localparam int AW    = $clog2(DEPTH);
   localparam int T_W   = XY_W - 1;          // clamped time is never negative
   localparam int Q1_W  = T_W + FRAC_W;      // segment index and fraction
   localparam int MAG_W = 2 * XY_W;          // |d * lookahead|

   typedef struct packed {
      logic            cmd;
      logic [TW-1:0]   tgt;
      logic            wr_en;
      logic [SW-1:0]   slot;
      logic [XY_W-1:0] wx;
      logic [XY_W-1:0] wy;
      logic [XY_W-1:0] la;
   } item_type;

   typedef struct packed {
      item_type          item;
      logic [FRAC_W-1:0] frac;
   } qitem_type;

   typedef struct packed {
      logic [XY_W-1:0] now;
      logic            neg;
   } axis_type;

   typedef struct packed {
      logic     cmd;
      axis_type ax;
   } xside_type;

   // target reduced modulo MAX_TARGETS, as a small constant table
   function automatic logic [TW-1:0] tgt_reduce(input logic [TARGET_W-1:0] v);
      logic [TW-1:0] r;
      r = '0;
      for (int k = 0; k < (1 << TARGET_W); k++) begin
         if (v == TARGET_W'(k)) begin
            r = TW'(k % MAX_TARGETS);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- config
   logic [STEP_COUNT_W-1:0] step_count_ff;
   logic [XY_W-1:0]         time_step_ff;
   logic [NW-1:0]           n_eff;
   logic [XY_W-1:0]         ts_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= '0;
         time_step_ff  <= XY_W'(65536);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_COUNT: step_count_ff <= csr_data[STEP_COUNT_W-1:0];
            CSR_TIME_STEP:  time_step_ff  <= csr_data;
            default:        time_step_ff  <= time_step_ff;
         endcase
      end
   end

   // saturate step count, treat a zero time step as one
   assign n_eff  = (32'(step_count_ff) > 32'(MAX_STEPS)) ? NW'(MAX_STEPS)
                                                         : NW'(step_count_ff);
   assign ts_eff = (time_step_ff == '0) ? XY_W'(1) : time_step_ff;

   // ------------------------------------------------------------ flow control
   logic [1:0] q_count_ff;
   logic       adv;

   assign adv       = (q_count_ff != 2'd2) || rsp_ready;
   assign req_ready = adv;

   // ------------------------------------------- time / time_step divider
   item_type          req_item;
   logic [T_W-1:0]    t_clamp;
   logic              d1_valid;
   logic [Q1_W-1:0]   d1_quo;
   item_type          d1_item;

   assign t_clamp          = req_query_time[XY_W-1] ? '0 : req_query_time[T_W-1:0];
   assign req_item.cmd     = req_cmd;
   assign req_item.tgt     = tgt_reduce(req_target);
   assign req_item.wr_en   = (32'(req_waypoint_slot) < 32'(MAX_STEPS));
   assign req_item.slot    = SW'(req_waypoint_slot);
   assign req_item.wx      = req_write_x;
   assign req_item.wy      = req_write_y;
   assign req_item.la      = req_lookahead;

   // quotient of (t << 16) / T: top bits index, low 16 bits fraction
   wip_div_pipe #(
      .NUM_W  (Q1_W),
      .DEN_W  (XY_W),
      .SIDE_W ($bits(item_type))
   ) u_time_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (req_valid),
      .in_num    ({t_clamp, {FRAC_W{1'b0}}}),
      .in_side   (req_item),
      .den       (ts_eff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_rem   (),
      .out_side  (d1_item)
   );

   // ------------------------------------------- segment index modulo n
   qitem_type d1_q;
   logic      m_valid;
   logic [NW-1:0] m_rem;
   qitem_type m_q;

   assign d1_q.item = d1_item;
   assign d1_q.frac = d1_quo[FRAC_W-1:0];

   wip_div_pipe #(
      .NUM_W  (T_W),
      .DEN_W  (NW),
      .SIDE_W ($bits(qitem_type))
   ) u_index_mod (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (d1_valid),
      .in_num    (d1_quo[Q1_W-1:FRAC_W]),
      .in_side   (d1_q),
      .den       (n_eff),
      .out_valid (m_valid),
      .out_quo   (),
      .out_rem   (m_rem),
      .out_side  (m_q)
   );

   // ------------------------------------------- waypoint store access
   // Writes and reads happen at this one stage in beat order, so a query
   // always sees exactly the writes accepted before it.
   logic [SW-1:0]   i0;
   logic [SW:0]     i0_inc;
   logic [SW-1:0]   i1;
   logic [AW-1:0]   row_base;
   logic [AW-1:0]   addr0;
   logic [AW-1:0]   addr1;
   logic [AW-1:0]   waddr;
   logic            ram_we;
   logic [XY_W-1:0] p0x_rd;
   logic [XY_W-1:0] p1x_rd;
   logic [XY_W-1:0] p0y_rd;
   logic [XY_W-1:0] p1y_rd;

   assign i0       = m_rem[SW-1:0];
   assign i0_inc   = {1'b0, i0} + 1'b1;
   assign i1       = (i0_inc == (SW+1)'(n_eff)) ? '0 : i0_inc[SW-1:0];
   assign row_base = AW'(m_q.item.tgt) * AW'(MAX_STEPS);
   assign addr0    = row_base + AW'(i0);
   assign addr1    = row_base + AW'(i1);
   assign waddr    = row_base + AW'(m_q.item.slot);
   assign ram_we   = adv && m_valid && (m_q.item.cmd == CMD_WRITE) && m_q.item.wr_en;

   wip_ram #(.WIDTH(XY_W), .DEPTH(DEPTH)) u_x_store (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (waddr),
      .wdata   (m_q.item.wx),
      .re      (adv),
      .raddr_a (addr0),
      .raddr_b (addr1),
      .rdata_a (p0x_rd),
      .rdata_b (p1x_rd)
   );

   wip_ram #(.WIDTH(XY_W), .DEPTH(DEPTH)) u_y_store (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (waddr),
      .wdata   (m_q.item.wy),
      .re      (adv),
      .raddr_a (addr0),
      .raddr_b (addr1),
      .rdata_a (p0y_rd),
      .rdata_b (p1y_rd)
   );

   logic      rd_valid_ff;
   qitem_type rd_ff;

   // ------------------------------------------- arithmetic stages
   // e1: segment deltas (exact, 33 bits)
   logic                   e1_valid_ff;
   logic                   e1_cmd_ff;
   logic [FRAC_W-1:0]      e1_frac_ff;
   logic [XY_W-1:0]        e1_la_ff;
   logic [XY_W-1:0]        e1_p0x_ff;
   logic [XY_W-1:0]        e1_p0y_ff;
   logic signed [XY_W:0]   e1_dx_ff;
   logic signed [XY_W:0]   e1_dy_ff;
   logic signed [XY_W:0]   e1_dx_in;
   logic signed [XY_W:0]   e1_dy_in;

   assign e1_dx_in = $signed({p1x_rd[XY_W-1], p1x_rd}) - $signed({p0x_rd[XY_W-1], p0x_rd});
   assign e1_dy_in = $signed({p1y_rd[XY_W-1], p1y_rd}) - $signed({p0y_rd[XY_W-1], p0y_rd});

   // e2: d * frac, and sign/magnitude for the lookahead product
   localparam int NP_W = XY_W + 1 + FRAC_W + 1;
   logic                   e2_valid_ff;
   logic                   e2_cmd_ff;
   logic [XY_W-1:0]        e2_p0x_ff;
   logic [XY_W-1:0]        e2_p0y_ff;
   logic signed [NP_W-1:0] e2_npx_ff;
   logic signed [NP_W-1:0] e2_npy_ff;
   logic [XY_W:0]          e2_mdx_ff;
   logic [XY_W:0]          e2_mdy_ff;
   logic [XY_W-1:0]        e2_ml_ff;
   logic                   e2_negx_ff;
   logic                   e2_negy_ff;
   logic signed [NP_W-1:0] e2_npx_in;
   logic signed [NP_W-1:0] e2_npy_in;

   assign e2_npx_in = e1_dx_ff * $signed({1'b0, e1_frac_ff});
   assign e2_npy_in = e1_dy_ff * $signed({1'b0, e1_frac_ff});

   // e3: now position, partial products of |d| * |lookahead|
   localparam int HI_W = XY_W + 1 - FRAC_W;
   logic                   e3_valid_ff;
   logic                   e3_cmd_ff;
   logic [XY_W-1:0]        e3_nowx_ff;
   logic [XY_W-1:0]        e3_nowy_ff;
   logic [HI_W+XY_W-1:0]   e3_phx_ff;
   logic [HI_W+XY_W-1:0]   e3_phy_ff;
   logic [FRAC_W+XY_W-1:0] e3_plx_ff;
   logic [FRAC_W+XY_W-1:0] e3_ply_ff;
   logic                   e3_negx_ff;
   logic                   e3_negy_ff;

   // e4: full magnitude product
   logic                   e4_valid_ff;
   logic                   e4_cmd_ff;
   logic [MAG_W-1:0]       e4_magx_ff;
   logic [MAG_W-1:0]       e4_magy_ff;
   xside_type              e4_xs_ff;
   axis_type               e4_ys_ff;
   logic [MAG_W-1:0]       e4_magx_in;
   logic [MAG_W-1:0]       e4_magy_in;

   assign e4_magx_in = MAG_W'({e3_phx_ff, {FRAC_W{1'b0}}} + (HI_W+XY_W+FRAC_W)'(e3_plx_ff));
   assign e4_magy_in = MAG_W'({e3_phy_ff, {FRAC_W{1'b0}}} + (HI_W+XY_W+FRAC_W)'(e3_ply_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
         e4_valid_ff <= 1'b0;
      end else if (adv) begin
         rd_valid_ff <= m_valid;
         e1_valid_ff <= rd_valid_ff;
         e2_valid_ff <= e1_valid_ff;
         e3_valid_ff <= e2_valid_ff;
         e4_valid_ff <= e3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff       <= m_q;
         // e1
         e1_cmd_ff   <= rd_ff.item.cmd;
         e1_frac_ff  <= rd_ff.frac;
         e1_la_ff    <= rd_ff.item.la;
         e1_p0x_ff   <= p0x_rd;
         e1_p0y_ff   <= p0y_rd;
         e1_dx_ff    <= e1_dx_in;
         e1_dy_ff    <= e1_dy_in;
         // e2
         e2_cmd_ff   <= e1_cmd_ff;
         e2_p0x_ff   <= e1_p0x_ff;
         e2_p0y_ff   <= e1_p0y_ff;
         e2_npx_ff   <= e2_npx_in;
         e2_npy_ff   <= e2_npy_in;
         e2_mdx_ff   <= e1_dx_ff[XY_W] ? (XY_W+1)'(-e1_dx_ff) : e1_dx_ff;
         e2_mdy_ff   <= e1_dy_ff[XY_W] ? (XY_W+1)'(-e1_dy_ff) : e1_dy_ff;
         e2_ml_ff    <= e1_la_ff[XY_W-1] ? XY_W'(-e1_la_ff) : e1_la_ff;
         e2_negx_ff  <= e1_dx_ff[XY_W] ^ e1_la_ff[XY_W-1];
         e2_negy_ff  <= e1_dy_ff[XY_W] ^ e1_la_ff[XY_W-1];
         // e3: arithmetic shift of d*frac by 16 is the floor
         e3_cmd_ff   <= e2_cmd_ff;
         e3_nowx_ff  <= e2_p0x_ff + e2_npx_ff[FRAC_W+XY_W-1:FRAC_W];
         e3_nowy_ff  <= e2_p0y_ff + e2_npy_ff[FRAC_W+XY_W-1:FRAC_W];
         e3_phx_ff   <= e2_mdx_ff[XY_W:FRAC_W] * e2_ml_ff;
         e3_phy_ff   <= e2_mdy_ff[XY_W:FRAC_W] * e2_ml_ff;
         e3_plx_ff   <= e2_mdx_ff[FRAC_W-1:0] * e2_ml_ff;
         e3_ply_ff   <= e2_mdy_ff[FRAC_W-1:0] * e2_ml_ff;
         e3_negx_ff  <= e2_negx_ff;
         e3_negy_ff  <= e2_negy_ff;
         // e4
         e4_cmd_ff   <= e3_cmd_ff;
         e4_magx_ff  <= e4_magx_in;
         e4_magy_ff  <= e4_magy_in;
         e4_xs_ff.cmd    <= e3_cmd_ff;
         e4_xs_ff.ax.now <= e3_nowx_ff;
         e4_xs_ff.ax.neg <= e3_negx_ff;
         e4_ys_ff.now    <= e3_nowy_ff;
         e4_ys_ff.neg    <= e3_negy_ff;
      end
   end

   // ------------------------------------------- |d * la| / T per axis
   logic             dx_valid;
   logic             dy_valid;
   logic [MAG_W-1:0] dx_quo;
   logic [MAG_W-1:0] dy_quo;
   logic [XY_W-1:0]  dx_rem;
   logic [XY_W-1:0]  dy_rem;
   xside_type        dx_side;
   axis_type         dy_side;

   wip_div_pipe #(
      .NUM_W  (MAG_W),
      .DEN_W  (XY_W),
      .SIDE_W ($bits(xside_type))
   ) u_ahead_div_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (e4_valid_ff && (e4_cmd_ff == e4_xs_ff.cmd)),
      .in_num    (e4_magx_ff),
      .in_side   (e4_xs_ff),
      .den       (ts_eff),
      .out_valid (dx_valid),
      .out_quo   (dx_quo),
      .out_rem   (dx_rem),
      .out_side  (dx_side)
   );

   wip_div_pipe #(
      .NUM_W  (MAG_W),
      .DEN_W  (XY_W),
      .SIDE_W ($bits(axis_type))
   ) u_ahead_div_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (e4_valid_ff),
      .in_num    (e4_magy_ff),
      .in_side   (e4_ys_ff),
      .den       (ts_eff),
      .out_valid (dy_valid),
      .out_quo   (dy_quo),
      .out_rem   (dy_rem),
      .out_side  (dy_side)
   );

   // ------------------------------------------- sign fix: negative rounds down
   logic            f_valid_ff;
   logic            f_cmd_ff;
   logic [XY_W-1:0] f_nowx_ff;
   logic [XY_W-1:0] f_nowy_ff;
   logic [XY_W-1:0] f_termx_ff;
   logic [XY_W-1:0] f_termy_ff;
   logic [XY_W-1:0] f_termx_in;
   logic [XY_W-1:0] f_termy_in;

   // only the low word matters: results wrap to 32 bits
   assign f_termx_in = dx_side.ax.neg ? (-(dx_quo[XY_W-1:0] + XY_W'(dx_rem != '0)))
                                      : dx_quo[XY_W-1:0];
   assign f_termy_in = dy_side.neg ? (-(dy_quo[XY_W-1:0] + XY_W'(dy_rem != '0)))
                                   : dy_quo[XY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= dx_valid && dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_cmd_ff   <= dx_side.cmd;
         f_nowx_ff  <= dx_side.ax.now;
         f_nowy_ff  <= dy_side.now;
         f_termx_ff <= f_termx_in;
         f_termy_ff <= f_termy_in;
      end
   end

   // ------------------------------------------- result select
   rsp_type res;

   always_comb begin
      res = '0;
      priority if (f_cmd_ff == CMD_WRITE) begin
         res = '0;
      end else if (n_eff == '0) begin
         res.no_waypoints = 1'b1;
      end else begin
         res.now_x   = f_nowx_ff;
         res.now_y   = f_nowy_ff;
         res.ahead_x = f_nowx_ff + f_termx_ff;
         res.ahead_y = f_nowy_ff + f_termy_ff;
      end
   end

   // ------------------------------------------- two-entry output queue
   rsp_type    q_ent_ff [2];
   logic       q_wr_ff;
   logic       q_rd_ff;
   logic       q_push;
   logic       q_pop;
   rsp_type    q_head;

   assign q_push = adv && f_valid_ff;
   assign q_pop  = rsp_valid && rsp_ready;
   assign q_head = q_ent_ff[q_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= '0;
         q_wr_ff    <= 1'b0;
         q_rd_ff    <= 1'b0;
      end else begin
         q_count_ff <= q_count_ff + 2'(q_push) - 2'(q_pop);
         if (q_push) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (q_pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ent_ff[q_wr_ff] <= res;
      end
   end

   assign rsp_valid        = (q_count_ff != '0);
   assign rsp_now_x        = q_head.now_x;
   assign rsp_now_y        = q_head.now_y;
   assign rsp_ahead_x      = q_head.ahead_x;
   assign rsp_ahead_y      = q_head.ahead_y;
   assign rsp_no_waypoints = q_head.no_waypoints;

endmodule

`default_nettype wire

FILE: src/wip_checker.sv
// ----------------------------------------------------------------------------
// wip_checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module wip_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [wip_pkg::XY_W-1:0] rsp_now_x,
   input logic signed [wip_pkg::XY_W-1:0] rsp_now_y,
   input logic signed [wip_pkg::XY_W-1:0] rsp_ahead_x,
   input logic signed [wip_pkg::XY_W-1:0] rsp_ahead_y,
   input logic                            rsp_no_waypoints
);

   import wip_pkg::*;

   // beats accepted but not yet returned
   logic [15:0] pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 16'(req_valid && req_ready) - 16'(rsp_valid && rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_now_x) && $stable(rsp_now_y)
         && $stable(rsp_ahead_x) && $stable(rsp_ahead_y) && $stable(rsp_no_waypoints))
      else $error("rsp beat changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_waypoints |-> rsp_now_x == '0 && rsp_now_y == '0
         && rsp_ahead_x == '0 && rsp_ahead_y == '0)
      else $error("no_waypoints result carries nonzero position");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("rsp beat without an accepted request");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind waypoint_interp_predict_core wip_checker u_wip_checker (.*);

`default_nettype wire

FILE: bench/waypoint_interp_predict_core_tb.sv
// ----------------------------------------------------------------------------
// waypoint_interp_predict_core_tb
// Self-checking bench: a queue-fed driver pushes waypoint writes and position
// queries, a clocked monitor scores every result beat against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module waypoint_interp_predict_core_tb;

   import wip_pkg::*;

   localparam int NUM_TARGETS = 16;
   localparam int NUM_STEPS   = 64;
   localparam int PIPE_DEPTH  = 149;     // total pipe stages, summed from the core header
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic        cmd;
      logic [3:0]  tgt;
      logic [5:0]  slot;
      logic [31:0] wx;
      logic [31:0] wy;
      logic [31:0] qt;
      logic [31:0] la;
   } req_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_cmd = CMD_WRITE;
   logic [TARGET_W-1:0]    req_target = '0;
   logic [SLOT_W-1:0]      req_waypoint_slot = '0;
   logic signed [XY_W-1:0] req_write_x = '0;
   logic signed [XY_W-1:0] req_write_y = '0;
   logic signed [XY_W-1:0] req_query_time = '0;
   logic signed [XY_W-1:0] req_lookahead = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [XY_W-1:0] rsp_now_x;
   logic signed [XY_W-1:0] rsp_now_y;
   logic signed [XY_W-1:0] rsp_ahead_x;
   logic signed [XY_W-1:0] rsp_ahead_y;
   logic                   rsp_no_waypoints;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = CSR_STEP_COUNT;
   logic [XY_W-1:0]        csr_data = '0;

   waypoint_interp_predict_core u_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_cmd, .req_target, .req_waypoint_slot,
      .req_write_x, .req_write_y, .req_query_time, .req_lookahead,
      .rsp_valid, .rsp_ready, .rsp_now_x, .rsp_now_y, .rsp_ahead_x, .rsp_ahead_y,
      .rsp_no_waypoints,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: register shadows and waypoint store copies
   logic [6:0]  step_count_q = 7'd0;
   logic [31:0] time_step_q  = 32'd65536;
   logic [31:0] x_store [0:NUM_TARGETS*NUM_STEPS-1];
   logic [31:0] y_store [0:NUM_TARGETS*NUM_STEPS-1];
   // generator-side record of which entries have been written
   bit          slot_written [0:NUM_TARGETS*NUM_STEPS-1];

   req_beat_type pending_beats[$];
   rsp_type      expected_positions[$];

   int          errors = 0;
   int          cycles = 0;
   int          writes_sent = 0, queries_sent = 0, empty_queries = 0, results_seen = 0;
   bit          idle_en = 1'b0;
   bit          req_taken = 1'b0, rsp_taken = 1'b0;
   int          req_gap = 0, rsp_stall = 0;

   // position at query time and after lookahead; writes update the store copy
   function automatic rsp_type predict_position(req_beat_type b);
      rsp_type             r;
      logic [63:0]         n, ts, t, q, frac, i0, i1;
      int                  base;
      logic signed [63:0]  p0, p1, d, now_pos, prod16;
      logic signed [127:0] prod, quo, den;
      r = '0;
      base = b.tgt * NUM_STEPS;
      if (b.cmd == CMD_WRITE) begin
         x_store[base + b.slot] = b.wx;
         y_store[base + b.slot] = b.wy;
         return r;
      end
      n  = (step_count_q > NUM_STEPS) ? NUM_STEPS : step_count_q;
      ts = (time_step_q == 0) ? 64'd1 : {32'd0, time_step_q};
      if (n == 0) begin
         r.no_waypoints = 1'b1;
         return r;
      end
      t    = b.qt[31] ? 64'd0 : {32'd0, b.qt};
      q    = t / ts;
      frac = ((t % ts) << 16) / ts;
      i0   = q % n;
      i1   = (i0 + 1 == n) ? 64'd0 : i0 + 1;
      den  = $signed({64'd0, ts});
      for (int axis = 0; axis < 2; axis++) begin
         p0 = $signed(axis == 0 ? x_store[base + i0] : y_store[base + i0]);
         p1 = $signed(axis == 0 ? x_store[base + i1] : y_store[base + i1]);
         d  = p1 - p0;
         prod16  = d * $signed(frac);
         now_pos = p0 + (prod16 >>> 16);
         prod = 128'(d) * 128'($signed(b.la));
         quo  = prod / den;
         if (prod < 0 && (prod % den) != 0) quo = quo - 1;   // floor, not truncate
         if (axis == 0) begin
            r.now_x   = now_pos[31:0];
            r.ahead_x = now_pos[31:0] + quo[31:0];
         end else begin
            r.now_y   = now_pos[31:0];
            r.ahead_y = now_pos[31:0] + quo[31:0];
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: hold a beat until taken, then optional gap, then next
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      req_beat_type b;
      if (!reset && !(req_valid && !req_taken)) begin
         req_taken <= 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            req_cmd           <= b.cmd;
            req_target        <= b.tgt;
            req_waypoint_slot <= b.slot;
            req_write_x       <= b.wx;
            req_write_y       <= b.wy;
            req_query_time    <= b.qt;
            req_lookahead     <= b.la;
            req_valid         <= 1'b1;
            req_gap = idle_en ? $urandom_range(0, 3) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp_ready: stall drawn per result beat
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_stall = idle_en ? $urandom_range(0, 3) : 0;
            rsp_taken <= 1'b0;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: predict on accepted requests, score accepted results
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_beat_type b;
      rsp_type      e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_positions.size());
         $display("FAIL");
         $finish;
      end
      if (!reset && req_valid && req_ready) begin
         b = '{req_cmd, req_target, req_waypoint_slot, req_write_x, req_write_y,
               req_query_time, req_lookahead};
         expected_positions.push_back(predict_position(b));
         req_taken <= 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken <= 1'b1;
         results_seen++;
         if (expected_positions.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat at cycle %0d", cycles);
         end else begin
            e = expected_positions.pop_front();
            if (rsp_now_x !== e.now_x || rsp_now_y !== e.now_y ||
                rsp_ahead_x !== e.ahead_x || rsp_ahead_y !== e.ahead_y ||
                rsp_no_waypoints !== e.no_waypoints) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch cyc %0d: now %h,%h ahead %h,%h none %b",
                            " / exp now %h,%h ahead %h,%h none %b"}, cycles,
                           rsp_now_x, rsp_now_y, rsp_ahead_x, rsp_ahead_y,
                           rsp_no_waypoints, e.now_x, e.now_y, e.ahead_x,
                           e.ahead_y, e.no_waypoints);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic csr_write(logic idx, logic [31:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == CSR_STEP_COUNT) step_count_q = data[6:0];
      else time_step_q = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers only change with the pipe empty and drained
   task automatic drain_and_configure(logic [31:0] steps, logic [31:0] tstep);
      wait (pending_beats.size() == 0 && !req_valid && expected_positions.size() == 0);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      csr_write(CSR_STEP_COUNT, steps);
      csr_write(CSR_TIME_STEP, tstep);
   endtask

   task automatic push_write(logic [3:0] tgt, logic [5:0] slot, logic [31:0] wx,
                             logic [31:0] wy);
      pending_beats.push_back('{CMD_WRITE, tgt, slot, wx, wy, $urandom, $urandom});
      slot_written[tgt * NUM_STEPS + slot] = 1'b1;
      writes_sent++;
   endtask

   // a query first fills in any waypoint it would read that was never written
   task automatic push_query(logic [3:0] tgt, logic [31:0] qt, logic [31:0] la);
      logic [63:0] n, ts, t, i0, i1;
      n  = (step_count_q > NUM_STEPS) ? NUM_STEPS : step_count_q;
      ts = (time_step_q == 0) ? 64'd1 : {32'd0, time_step_q};
      if (n != 0) begin
         t  = qt[31] ? 64'd0 : {32'd0, qt};
         i0 = (t / ts) % n;
         i1 = (i0 + 1 == n) ? 64'd0 : i0 + 1;
         if (!slot_written[tgt * NUM_STEPS + i0])
            push_write(tgt, i0[5:0], $urandom, $urandom);
         if (!slot_written[tgt * NUM_STEPS + i1])
            push_write(tgt, i1[5:0], $urandom, $urandom);
      end else begin
         empty_queries++;
      end
      pending_beats.push_back('{CMD_QUERY, tgt, 6'($urandom), $urandom, $urandom, qt, la});
      queries_sent++;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_time();
      logic [63:0] span;
      span = 64'(time_step_q) * 64'(step_count_q + 2);
      case ($urandom_range(0, 5))
         0:       return $urandom;                       // includes negatives
         1:       return 32'h7fff_ffff;
         default: return (span > 64'h7fff_ffff) ? $urandom_range(0, 32'h7fff_ffff)
                                                 : $urandom_range(0, span[31:0]);
      endcase
   endfunction

   // beats counts every item pushed in the phase, fill writes included
   task automatic random_phase(logic [31:0] steps, logic [31:0] tstep, int beats);
      int start;
      drain_and_configure(steps, tstep);
      start   = writes_sent + queries_sent;
      idle_en = ($urandom_range(0, 3) != 0);
      while (writes_sent + queries_sent - start < beats) begin
         if ($urandom_range(0, 9) < 3)
            push_write(4'($urandom), 6'($urandom), pick_coord(), pick_coord());
         else
            push_query(4'($urandom), pick_time(), pick_coord());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty step count, then extremes on a four-point loop
      drain_and_configure(0, 65536);
      push_query(4'd0, 32'd100, 32'd5);
      push_write(4'd15, 6'd0, 32'h8000_0000, 32'h7fff_ffff);
      push_query(4'd15, 32'h7fff_ffff, 32'h8000_0000);
      drain_and_configure(4, 65536);
      push_write(4'd15, 6'd1, 32'h7fff_ffff, 32'h8000_0000);
      push_write(4'd15, 6'd2, 32'h0, 32'hffff_ffff);
      push_write(4'd15, 6'd3, 32'h0001_0000, 32'h0);
      push_write(4'd3, 6'd63, 32'h1234_5678, 32'h8765_4321);   // slot past step count
      push_query(4'd15, 32'hffff_ffff, 32'h0001_0000);         // negative time clamps
      push_query(4'd15, 32'h8000_0000, 32'h7fff_ffff);
      push_query(4'd15, 32'h0, 32'h0);
      push_query(4'd15, 32'h0000_8000, 32'h8000_0000);         // halfway, max min lookahead
      push_query(4'd15, 32'h0003_c000, 32'h7fff_ffff);         // last segment wraps to first
      push_query(4'd15, 32'h0004_0000, 32'hffff_0000);         // exactly one full loop
      push_query(4'd15, 32'h7fff_ffff, 32'h7fff_ffff);
      push_query(4'd15, 32'h0001_ffff, 32'h8000_0001);
      drain_and_configure(127, 0);                             // saturated count, zero step
      push_query(4'd15, 32'h0000_0003, 32'h0000_0002);
      push_query(4'd15, 32'h7fff_ffff, 32'hffff_ffff);

      random_phase(64, 32'hffff_ffff, 160);
      random_phase(1, 1, 150);
      random_phase(2, 65536, 160);
      random_phase(37, $urandom_range(1, 32'h0010_0000), 170);
      random_phase(64, $urandom_range(1, 32'h0004_0000), 180);
      random_phase(127, $urandom, 160);
      random_phase(0, 65536, 40);
      random_phase(13, 32'h0000_8000, 90);

      wait (pending_beats.size() == 0 && !req_valid && expected_positions.size() == 0);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      errors += expected_positions.size();
      $display("run covered %0d waypoint writes and %0d queries (%0d with no waypoints),",
               writes_sent, queries_sent, empty_queries);
      $display("%0d result beats scored over several register settings, %0d errors",
               results_seen, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
